FILE: rtl/stlp_pkg.sv
`default_nettype none

package stlp_pkg;

  // Result widths
  localparam int LongBits   = 32;
  localparam int OffsetBits = 16;
  localparam int BaseBits   = 6;
  localparam int ProdBits   = LongBits + BaseBits;

  localparam logic [LongBits-1:0] PosLimit = {1'b0, {(LongBits-1){1'b1}}};
  localparam logic [LongBits-1:0] NegLimit = {1'b1, {(LongBits-1){1'b0}}};
  localparam logic [OffsetBits-1:0] CountMax = {OffsetBits{1'b1}};

  // Radix codes
  localparam logic [BaseBits-1:0] BaseAuto = 6'd0;
  localparam logic [BaseBits-1:0] BaseMin  = 6'd2;
  localparam logic [BaseBits-1:0] BaseOct  = 6'd8;
  localparam logic [BaseBits-1:0] BaseDec  = 6'd10;
  localparam logic [BaseBits-1:0] BaseHex  = 6'd16;
  localparam logic [BaseBits-1:0] BaseMax  = 6'd36;
  localparam logic [BaseBits-1:0] NoDigit  = 6'd63;

  // Character codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowZ  = 8'h7A;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } stlp_in_t;

  typedef struct packed {
    logic signed [LongBits-1:0] parsed_value;
    logic [OffsetBits-1:0]      end_offset;
    logic                       converted;
    logic                       overflowed;
  } stlp_out_t;

  // Value of an alphanumeric character, NoDigit for anything else
  function automatic logic [BaseBits-1:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      v = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      v = c - ChUpA + 8'd10;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      v = c - ChLowA + 8'd10;
    end else begin
      v = {2'b00, NoDigit};
    end
    return v[BaseBits-1:0];
  endfunction

  function automatic logic [OffsetBits-1:0] sat_inc(input logic [OffsetBits-1:0] n);
    return (n == CountMax) ? n : n + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/string_to_long_parser_core.sv
// The result of the character that ends the number (first non-digit) is
//   registered into out_data_o, or into the skid register while the output is held.
// Throughput: one character per cycle, multiply-add and limit compare between
//   the state and result registers; in_ready_o drops only while both the
//   output register and the skid register hold results.
// Reset (rst_ni, async, active low): idle the parser, empty both result registers, radix 10.
`default_nettype none

module string_to_long_parser_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_write_i,
  input  wire logic [5:0]             cfg_data_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire stlp_pkg::stlp_in_t     in_data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      stlp_pkg::stlp_out_t    out_data_o
);
  import stlp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_FIRST,
    PH_ZERO,
    PH_X,
    PH_DIGITS
  } phase_e;

  // Radix register; the user must write it only while the parser is idle, the block does not enforce it
  logic [BaseBits-1:0] number_base_q;

  // Parse state
  phase_e                phase_q, phase_d, phase_eff;
  logic                  neg_q, neg_d, neg_eff;
  logic [LongBits-1:0]   acc_q, acc_d, acc_eff;
  logic                  ovf_q, ovf_d, ovf_eff;
  logic                  dig_q, dig_d, dig_eff;
  logic [OffsetBits-1:0] cnt_q, cnt_d, cnt_eff;
  logic [BaseBits-1:0]   base_q, base_d, base_eff;

  // Result queue: output register plus one skid entry
  logic      out_valid_q, skid_valid_q;
  stlp_out_t out_q, skid_q;

  logic                  in_fire, out_fire;
  logic [7:0]            ch;
  logic [BaseBits-1:0]   digit;
  logic                  is_ws, is_sign, is_x, is_hex;
  logic                  first, take, fin;
  logic [BaseBits-1:0]   td_base;
  logic                  td_dig;
  logic [OffsetBits-1:0] td_cnt;
  logic [ProdBits-1:0]   prod, limit_w;
  logic                  bad_digit;
  stlp_out_t             res;

  assign in_ready_o  = ~skid_valid_q;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ch      = in_data_i.char_code;
  assign digit   = digit_value(ch);
  assign is_ws   = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
  assign is_sign = (ch == ChPlus) || (ch == ChMinus);
  assign is_x    = (ch == ChLowX) || (ch == ChUpX);
  assign is_hex  = (digit < BaseHex);

  // A start character restarts from a clean state before it is parsed
  always_comb begin
    if (in_data_i.string_start) begin
      phase_eff = PH_SPACE;
      neg_eff   = 1'b0;
      acc_eff   = '0;
      ovf_eff   = 1'b0;
      dig_eff   = 1'b0;
      cnt_eff   = '0;
      base_eff  = number_base_q;
    end else begin
      phase_eff = phase_q;
      neg_eff   = neg_q;
      acc_eff   = acc_q;
      ovf_eff   = ovf_q;
      dig_eff   = dig_q;
      cnt_eff   = cnt_q;
      base_eff  = base_q;
    end
  end

  // Character classification and phase steering
  always_comb begin
    phase_d = phase_eff;
    neg_d   = neg_eff;
    acc_d   = acc_eff;
    ovf_d   = ovf_eff;
    dig_d   = dig_eff;
    cnt_d   = cnt_eff;
    base_d  = base_eff;
    first   = 1'b0;
    take    = 1'b0;
    fin     = 1'b0;
    td_base = base_eff;
    td_dig  = dig_eff;
    td_cnt  = cnt_eff;

    unique case (phase_eff)
      PH_SPACE: begin
        if (is_ws) begin
          cnt_d = sat_inc(cnt_eff);
        end else if (is_sign) begin
          neg_d   = (ch == ChMinus);
          cnt_d   = sat_inc(cnt_eff);
          phase_d = PH_FIRST;
        end else begin
          first = 1'b1;
        end
      end
      PH_FIRST: first = 1'b1;
      PH_ZERO: begin
        if (is_x) begin
          // Hold the 'x' uncounted until a hex digit confirms the prefix
          phase_d = PH_X;
        end else begin
          td_base = (base_eff == BaseAuto) ? BaseOct : base_eff;
          td_dig  = 1'b1;
          take    = 1'b1;
        end
      end
      PH_X: begin
        if (is_hex) begin
          td_base = BaseHex;
          td_cnt  = sat_inc(cnt_eff);
          take    = 1'b1;
        end else begin
          // Bare prefix: only the leading zero converts
          base_d = (base_eff == BaseAuto) ? BaseOct : base_eff;
          dig_d  = 1'b1;
          fin    = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      PH_IDLE: ;
      default: ;
    endcase

    if (first) begin
      if ((base_eff == BaseAuto || base_eff == BaseHex) && ch == ChZero) begin
        phase_d = PH_ZERO;
        cnt_d   = sat_inc(cnt_eff);
      end else begin
        td_base = (base_eff == BaseAuto) ? BaseDec : base_eff;
        take    = 1'b1;
      end
    end

    // Digit step: multiply-add and saturate against the signed limit
    prod      = ProdBits'(acc_eff) * ProdBits'(td_base) + ProdBits'(digit);
    limit_w   = ProdBits'(neg_eff ? NegLimit : PosLimit);
    bad_digit = (td_base < BaseMin) || (td_base > BaseMax) || (digit >= td_base);

    if (take) begin
      base_d  = td_base;
      dig_d   = td_dig;
      cnt_d   = td_cnt;
      phase_d = PH_DIGITS;
      if (bad_digit) begin
        fin = 1'b1;
      end else begin
        if (!ovf_eff && prod <= limit_w) begin
          acc_d = prod[LongBits-1:0];
        end else begin
          ovf_d = 1'b1;
        end
        dig_d = 1'b1;
        cnt_d = sat_inc(td_cnt);
      end
    end

    if (fin) begin
      phase_d = PH_IDLE;
    end
  end

  // Result formed from the state at the end of the number
  always_comb begin
    res = '0;
    if (dig_d) begin
      if (ovf_d) begin
        res.parsed_value = neg_d ? NegLimit : PosLimit;
      end else begin
        res.parsed_value = neg_d ? (~acc_d + 1'b1) : acc_d;
      end
      res.end_offset = cnt_d;
      res.converted  = 1'b1;
      res.overflowed = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseDec;
      phase_q       <= PH_IDLE;
      neg_q         <= 1'b0;
      acc_q         <= '0;
      ovf_q         <= 1'b0;
      dig_q         <= 1'b0;
      cnt_q         <= '0;
      base_q        <= '0;
    end else begin
      if (cfg_write_i) begin
        number_base_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        dig_q   <= dig_d;
        cnt_q   <= cnt_d;
        base_q  <= base_d;
      end
    end
  end

  // Output register with skid entry; a new result goes to the skid only
  // when the output register is occupied and not draining this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire & fin;
        end
      end else if (in_fire && fin) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire && fin) begin
        out_q <= res;
      end
    end else if (in_fire && fin) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stlp_checker.sv
`default_nettype none

module stlp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire stlp_pkg::stlp_out_t out_data_o
);
  import stlp_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input stalls only with a full output register
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // No conversion gives an all-zero result
  a_no_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.converted |->
      out_data_o.parsed_value == '0 && out_data_o.end_offset == '0 &&
      !out_data_o.overflowed)
    else $error("nonzero result without conversion");

  // Clamped results sit at a limit
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflowed |->
      out_data_o.converted &&
      (out_data_o.parsed_value == NegLimit || out_data_o.parsed_value == PosLimit))
    else $error("overflow flag without saturated value");

  // A consumed digit always advances the end offset
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.converted |-> out_data_o.end_offset != '0)
    else $error("conversion with zero end offset");

endmodule

bind string_to_long_parser_core stlp_checker u_stlp_checker (.*);

`default_nettype wire

FILE: tb/string_to_long_parser_core_tb.sv
`timescale 1ns / 100ps

module string_to_long_parser_core_tb;
  import stlp_pkg::*;

  localparam int HoldCycles  = 80;         // long output hold-off that backs up the parser
  localparam int CycleLimit  = 1_000_000;  // far above the worst-case run with all idling
  localparam int DrainCycles = 4;          // settle time after the last expected result
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChHigh = 8'hFF;

  // Parser phases of the expected-value predictor
  typedef enum logic [2:0] {
    ScanIdle, ScanSpace, ScanSign, ScanZero, ScanPrefix, ScanDigits
  } scan_phase_e;

  // Predicts the number each string yields and matches it against the output.
  class number_scoreboard;
    stlp_out_t           pending_numbers[$];
    int unsigned         errors;
    logic [BaseBits-1:0] radix_reg;
    logic [BaseBits-1:0] radix;
    scan_phase_e         phase;
    logic                negative;
    logic                saturated;
    logic                has_digit;
    logic [LongBits-1:0] magnitude;
    logic [OffsetBits-1:0] consumed;

    function new();
      errors    = 0;
      radix_reg = BaseDec;
      radix     = BaseAuto;
      phase     = ScanIdle;
      negative  = 1'b0;
      saturated = 1'b0;
      has_digit = 1'b0;
      magnitude = '0;
      consumed  = '0;
    endfunction

    function void write_radix(logic [BaseBits-1:0] b);
      radix_reg = b;
    endfunction

    function int char_weight(logic [7:0] c);
      if (c >= ChZero && c <= ChNine) return int'(c) - int'(ChZero);
      if (c >= ChUpA && c <= ChUpZ) return int'(c) - int'(ChUpA) + 10;
      if (c >= ChLowA && c <= ChLowZ) return int'(c) - int'(ChLowA) + 10;
      return int'(NoDigit);
    endfunction

    function void count_char();
      if (consumed != CountMax) consumed++;
    endfunction

    function void close_number();
      stlp_out_t r;
      r = '0;
      if (has_digit) begin
        if (saturated) r.parsed_value = negative ? NegLimit : PosLimit;
        else r.parsed_value = negative ? ({LongBits{1'b0}} - magnitude) : magnitude;
        r.end_offset = consumed;
        r.converted  = 1'b1;
        r.overflowed = saturated;
      end
      pending_numbers.push_back(r);
      phase = ScanIdle;
    endfunction

    function void accumulate(logic [7:0] c);
      int d;
      longint unsigned lim, cut, cut_rem;
      d = char_weight(c);
      phase = ScanDigits;
      if (radix < BaseMin || radix > BaseMax || d >= radix) begin
        close_number();
        return;
      end
      lim     = negative ? NegLimit : PosLimit;
      cut     = lim / radix;
      cut_rem = lim % radix;
      if (saturated || magnitude > cut || (magnitude == cut && d > cut_rem)) saturated = 1'b1;
      else magnitude = LongBits'(longint'(magnitude) * radix + d);
      has_digit = 1'b1;
      count_char();
    endfunction

    function void lead_char(logic [7:0] c);
      if ((radix == BaseAuto || radix == BaseHex) && c == ChZero) begin
        phase = ScanZero;
        count_char();
        return;
      end
      if (radix == BaseAuto) radix = BaseDec;
      accumulate(c);
    endfunction

    // Advance the predictor by one accepted character transaction.
    function void feed_char(stlp_in_t t);
      logic [7:0] c;
      c = t.char_code;
      if (t.string_start) begin
        phase     = ScanSpace;
        negative  = 1'b0;
        magnitude = '0;
        saturated = 1'b0;
        has_digit = 1'b0;
        consumed  = '0;
        radix     = radix_reg;
      end
      case (phase)
        ScanSpace: begin
          if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
            count_char();
          end else if (c == ChMinus || c == ChPlus) begin
            negative = (c == ChMinus);
            count_char();
            phase = ScanSign;
          end else begin
            lead_char(c);
          end
        end
        ScanSign: lead_char(c);
        ScanZero: begin
          if (c == ChLowX || c == ChUpX) begin
            phase = ScanPrefix;
          end else begin
            if (radix == BaseAuto) radix = BaseOct;
            has_digit = 1'b1;
            accumulate(c);
          end
        end
        ScanPrefix: begin
          if (char_weight(c) < int'(BaseHex)) begin
            radix = BaseHex;
            count_char();
            accumulate(c);
          end else begin
            // "0x" with no hex digit: only the zero counts
            if (radix == BaseAuto) radix = BaseOct;
            has_digit = 1'b1;
            close_number();
          end
        end
        ScanDigits: accumulate(c);
        default: ;
      endcase
    endfunction

    function void match_number(stlp_out_t got);
      stlp_out_t want;
      if (pending_numbers.size() == 0) begin
        $error("unexpected result: parsed_value %0d end_offset %0d",
               got.parsed_value, got.end_offset);
        errors++;
        return;
      end
      want = pending_numbers.pop_front();
      if (got.parsed_value !== want.parsed_value) begin
        $error("parsed_value: expected %0d, got %0d", want.parsed_value, got.parsed_value);
        errors++;
      end
      if (got.end_offset !== want.end_offset) begin
        $error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
        errors++;
      end
      if (got.converted !== want.converted) begin
        $error("converted: expected %0b, got %0b", want.converted, got.converted);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_write;
  logic [5:0]      cfg_data;
  logic            in_valid;
  logic            in_ready;
  stlp_in_t        in_data;
  logic            out_valid;
  logic            out_ready;
  stlp_out_t       out_data;

  number_scoreboard sb;
  stlp_in_t         char_q[$];     // characters waiting to be offered
  bit               start_next;    // next queued char opens a new string
  bit               tx_calm;       // sender offers back to back
  bit               rx_calm;       // receiver never stalls
  bit               hold_req;      // ask the receiver for one long hold-off
  int unsigned      cycles;

  string dec_edges[5] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                          "-0002147483647"};
  string hex_edges[5] = '{"7fffffff", "80000000", "-80000000", "-80000001", "0X7FFFFFFF"};

  string_to_long_parser_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_write_i (cfg_write),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs or loses a result.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result transaction; outputs are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_number(out_data);
  end

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_char(logic [7:0] c);
    stlp_in_t t;
    t.char_code    = c;
    t.string_start = start_next;
    start_next     = 1'b0;
    char_q.push_back(t);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // Map a digit weight to its character, letters in random case.
  function automatic logic [7:0] digit_char(int dv);
    if (dv < 10) return 8'(int'(ChZero) + dv);
    return 8'(($urandom_range(0, 1) ? int'(ChUpA) : int'(ChLowA)) + dv - 10);
  endfunction

  // Queue random strings for radix b until about target chars are consumed.
  task automatic queue_strings(int target, logic [5:0] b);
    int  made, ignored, kind, n, top;
    bit  prefixed;
    made    = char_q.size();
    ignored = 0;
    while (char_q.size() - made - ignored < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // noise: any byte, sometimes opening a string
        start_next = ($urandom_range(0, 3) == 0);
        add_char(8'($urandom_range(0, 255)));
      end else if (kind < 14 && (b == BaseDec || b == BaseAuto)) begin
        start_next = 1'b1;
        add_text(dec_edges[$urandom_range(0, 4)]);
        add_char(ChNul);
      end else if (kind < 14 && b == BaseHex) begin
        start_next = 1'b1;
        add_text(hex_edges[$urandom_range(0, 4)]);
        add_char(ChNul);
      end else begin
        start_next = 1'b1;
        n = $urandom_range(0, 9);
        repeat ((n < 6) ? 0 : n - 5)
          add_char($urandom_range(0, 1) ? ChSpace : 8'(ChTab + $urandom_range(0, 4)));
        n = $urandom_range(0, 2);
        if (n == 1) add_char(ChPlus);
        if (n == 2) add_char(ChMinus);
        prefixed = ($urandom_range(0, 3) == 0);
        if (prefixed) begin
          add_char(ChZero);
          add_char($urandom_range(0, 1) ? ChLowX : ChUpX);
        end
        top = (b >= BaseMin && b <= BaseMax) ? int'(b) : int'(BaseMax);
        if (prefixed && (b == BaseAuto || b == BaseHex)) top = int'(BaseHex);
        else if (b == BaseAuto) top = int'(BaseDec);
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
        repeat (n) add_char(digit_char($urandom_range(0, top - 1)));
        // leave some strings open so the next start drops them
        if ($urandom_range(0, 19) != 0)
          add_char(($urandom_range(0, 2) == 0) ? ChNul : 8'($urandom_range(0, 255)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) add_char(8'($urandom_range(0, 255)));
        ignored += n;
      end
    end
  endtask

  // Offer every queued char; entered and left at a falling edge.
  task automatic send_chars();
    stlp_in_t t;
    int       gap;
    while (char_q.size() != 0) begin
      t   = char_q.pop_front();
      gap = tx_calm ? 0 : idle_len();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= t;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.feed_char(t);
      @(negedge clk);
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every expected number is out, then let the tail settle.
  task automatic wait_drained();
    while (sb.pending_numbers.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Write the radix register; only called with the parser drained.
  task automatic write_radix(logic [5:0] b);
    cfg_write <= 1'b1;
    cfg_data  <= b;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_radix(b);
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin : rx_side
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_calm) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : main_seq
    int radix_plan[11];
    int k;
    sb         = new();
    cycles     = 0;
    rst_n      = 1'b0;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    start_next = 1'b0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_req   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset radix is decimal: leading tab, plus sign, then a letter ends the number.
    start_next = 1'b1;
    add_char(ChTab);
    add_text("+9a");
    // stray char while idle: ignored
    add_char("7");
    // an unfinished string is dropped by the next start
    start_next = 1'b1;
    add_text("12");
    start_next = 1'b1;
    add_char("3");
    add_char(ChNul);
    send_chars();
    wait_drained();

    // Auto radix: bare "0x" converts the zero only; "-0Xf" switches to hex.
    write_radix(BaseAuto);
    start_next = 1'b1;
    add_text("0xg");
    start_next = 1'b1;
    add_text("-0Xf ");
    send_chars();
    wait_drained();

    // Invalid radix: no conversion at all.
    write_radix(6'd1);
    start_next = 1'b1;
    add_char("5");
    send_chars();
    wait_drained();

    // Top radix: six z's overflow a negative value; 0xFF ends it.
    write_radix(BaseMax);
    start_next = 1'b1;
    add_text("-zzzzzz");
    add_char(ChHigh);
    send_chars();
    wait_drained();

    // Random strings over a spread of radix settings, extremes included.
    radix_plan = '{10, 0, 16, 2, 8, 36, 63, 1, 3, -1, -1};
    for (k = 0; k < 11; k++) begin
      if (radix_plan[k] < 0) radix_plan[k] = $urandom_range(0, 63);
      write_radix(6'(radix_plan[k]));
      // one stretch with no idling on either side
      tx_calm = (k == 4);
      rx_calm = (k == 4);
      queue_strings(135, 6'(radix_plan[k]));
      send_chars();
      wait_drained();
      if (k == 0) begin
        // Back up the block: hold the output while short numbers keep arriving.
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        repeat (24) begin
          start_next = 1'b1;
          add_char("1");
          add_char(ChNul);
        end
        send_chars();
        tx_calm = 1'b0;
        wait_drained();
      end
    end

    if (sb.errors == 0 && sb.pending_numbers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
